FILE: hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

// Check a condition in the cycle after a trigger.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/i2ew_pkg.sv
package i2ew_pkg;

   localparam int VALUE_WIDTH         = 31;
   localparam int CODE_WIDTH          = 5;
   localparam int NUM_DIGITS          = 10;
   localparam int NUM_GROUPS          = 4;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   typedef logic [VALUE_WIDTH-1:0]      value_type;
   typedef logic [CODE_WIDTH-1:0]       code_type;
   typedef logic [3:0]                  digit_type;
   typedef logic [NUM_DIGITS-1:0][3:0]  digits_type;

   localparam code_type CODE_ZERO      = 5'd0;
   localparam code_type CODE_TEN       = 5'd10;
   localparam code_type CODE_TENS_BASE = 5'd18;
   localparam code_type CODE_HUNDRED   = 5'd28;
   localparam code_type CODE_THOUSAND  = 5'd29;
   localparam code_type CODE_MILLION   = 5'd30;
   localparam code_type CODE_BILLION   = 5'd31;

   localparam code_type SCALE_CODE [NUM_GROUPS] =
      '{CODE_BILLION, CODE_MILLION, CODE_THOUSAND, CODE_ZERO};

endpackage

FILE: hdl/i2ew_if.sv
interface i2ew_req_if;
   import i2ew_pkg::*;

   logic      valid;
   logic      ready;
   value_type value;

   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

interface i2ew_rsp_if;
   import i2ew_pkg::*;

   logic     valid;
   logic     ready;
   code_type word_code;
   logic     last_word;

   modport source (output valid, output word_code, output last_word, input ready);
   modport sink (input valid, input word_code, input last_word, output ready);
endinterface

FILE: hdl/i2ew_front.sv
module i2ew_front (
   input  logic                  clock,
   input  logic                  reset,
   i2ew_req_if.sink              req,
   output logic                  push_valid,
   output i2ew_pkg::digits_type  push_data,
   input  logic                  push_ready
);
   import i2ew_pkg::*;

   localparam int CNT_W = $clog2(VALUE_WIDTH);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_PUSH
   } state_type;

   state_type        state_ff;
   value_type        bin_ff;
   digits_type       bcd_ff;
   logic [CNT_W-1:0] cnt_ff;
   digits_type       bcd_in;

   function automatic digits_type adjust(digits_type d);
      digits_type r;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         r[i] = (d[i] >= 4'd5) ? d[i] + 4'd3 : d[i];
      end
      return r;
   endfunction

   always_comb begin
      digits_type             a;
      logic [4*NUM_DIGITS:0]  shifted;
      a = adjust(bcd_ff);
      shifted = {a, bin_ff[VALUE_WIDTH-1]};
      bcd_in = shifted[4*NUM_DIGITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req.valid) begin
                  bin_ff   <= req.value;
                  bcd_ff   <= '0;
                  cnt_ff   <= '0;
                  state_ff <= ST_CONV;
               end
            end
            ST_CONV: begin
               bcd_ff <= bcd_in;
               bin_ff <= bin_ff << 1;
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(VALUE_WIDTH - 1)) begin
                  state_ff <= ST_PUSH;
               end
            end
            ST_PUSH: begin
               if (push_ready) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req.ready  = (state_ff == ST_IDLE);
   assign push_valid = (state_ff == ST_PUSH);
   assign push_data  = bcd_ff;

endmodule

FILE: hdl/i2ew_queue.sv
module i2ew_queue #(
   parameter int DEPTH = i2ew_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   input  i2ew_pkg::digits_type  push_data,
   output logic                  push_ready,
   output logic                  pop_valid,
   output i2ew_pkg::digits_type  pop_data,
   input  logic                  pop_ready
);
   import i2ew_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   digits_type       entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             push;
   logic             pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: hdl/i2ew_back.sv
`include "assert_macros.svh"

module i2ew_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  pop_valid,
   input  i2ew_pkg::digits_type  pop_data,
   output logic                  pop_ready,
   i2ew_rsp_if.source            rsp
);
   import i2ew_pkg::*;

   localparam int STEPS      = 5;
   localparam int PAD_DIGITS = NUM_GROUPS * 3;
   localparam int MASK_W     = NUM_GROUPS * STEPS + 1;
   localparam int ZERO_BIT   = MASK_W - 1;

   typedef logic [MASK_W-1:0]          mask_type;
   typedef logic [PAD_DIGITS-1:0][3:0] pad_type;

   logic       busy_ff;
   logic       busy_in;
   mask_type   mask_ff;
   mask_type   mask_in;
   digits_type digits_ff;
   mask_type   onehot;
   code_type   code_vec [MASK_W];
   code_type   word_sel;
   logic       rsp_fire;

   function automatic mask_type word_mask(digits_type d);
      pad_type   p;
      mask_type  m;
      digit_type h;
      digit_type t;
      digit_type u;
      p = pad_type'(d);
      m = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         h = p[PAD_DIGITS - 1 - 3*g];
         t = p[PAD_DIGITS - 2 - 3*g];
         u = p[PAD_DIGITS - 3 - 3*g];
         m[STEPS*g]     = (h != 4'd0);
         m[STEPS*g + 1] = (h != 4'd0);
         m[STEPS*g + 2] = (t != 4'd0);
         m[STEPS*g + 3] = (u != 4'd0) && (t != 4'd1);
         m[STEPS*g + 4] = ((h | t | u) != 4'd0) && (g < NUM_GROUPS - 1);
      end
      m[ZERO_BIT] = (d == '0);
      return m;
   endfunction

   always_comb begin
      pad_type   p;
      digit_type h;
      digit_type t;
      digit_type u;
      p = pad_type'(digits_ff);
      for (int g = 0; g < NUM_GROUPS; g++) begin
         h = p[PAD_DIGITS - 1 - 3*g];
         t = p[PAD_DIGITS - 2 - 3*g];
         u = p[PAD_DIGITS - 3 - 3*g];
         code_vec[STEPS*g]     = code_type'(h);
         code_vec[STEPS*g + 1] = CODE_HUNDRED;
         code_vec[STEPS*g + 2] = (t == 4'd1) ? CODE_TEN + code_type'(u)
                                             : CODE_TENS_BASE + code_type'(t);
         code_vec[STEPS*g + 3] = code_type'(u);
         code_vec[STEPS*g + 4] = SCALE_CODE[g];
      end
      code_vec[ZERO_BIT] = CODE_ZERO;
   end

   always_comb begin
      onehot   = mask_ff & (~mask_ff + 1'b1);
      word_sel = '0;
      for (int k = 0; k < MASK_W; k++) begin
         word_sel = word_sel | (onehot[k] ? code_vec[k] : '0);
      end
   end

   assign rsp.valid     = busy_ff;
   assign rsp.word_code = word_sel;
   assign rsp.last_word = ((mask_ff & ~onehot) == '0);
   assign rsp_fire      = rsp.valid && rsp.ready;
   assign pop_ready     = !busy_ff;

   always_comb begin
      busy_in = busy_ff;
      mask_in = mask_ff;
      if (!busy_ff) begin
         if (pop_valid) begin
            busy_in = 1'b1;
            mask_in = word_mask(pop_data);
         end
      end else if (rsp_fire) begin
         mask_in = mask_ff & ~onehot;
         busy_in = !rsp.last_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         mask_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!busy_ff && pop_valid) begin
         digits_ff <= pop_data;
      end
   end

   `ASSERT_ALWAYS(a_busy_has_word, !busy_ff || (mask_ff != '0), "busy with no word left")
   `ASSERT_NEXT(a_last_ends_item, rsp_fire && rsp.last_word, !busy_ff, "busy after last word")
   `ASSERT_ALWAYS(a_zero_alone, !(busy_ff && mask_ff[ZERO_BIT]) || (mask_ff[ZERO_BIT-1:0] == '0), "zero word mixed with others")
   `ASSERT_NEXT(a_word_retires, rsp_fire && !rsp.last_word, busy_ff && ($countones(mask_ff) == $countones($past(mask_ff)) - 1), "word not retired")

endmodule

FILE: hdl/integer_to_english_word_tokens.sv
// Channel   Dir  Payload                         Accepted when
// req_chan  in   value[30:0]                     valid && ready
// rsp_chan  out  word_code[4:0], last_word       valid && ready
//
// A request passes through the front states in order: ST_IDLE accepts it, ST_CONV
// runs the bit-serial binary to decimal loop and ST_PUSH hands the digits to the queue.
// After loading, the back emits 1 to 16 words, one per cycle unless rsp_chan stalls.
// The front takes no new request until the last one's digits are in the queue.
// Reset is synchronous and clears the front state, queue pointers and back state.
// A stalled rsp_chan fills the queue before req_chan stops accepting.
module integer_to_english_word_tokens #(
   parameter int QUEUE_DEPTH = i2ew_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   i2ew_req_if.sink     req_chan,
   i2ew_rsp_if.source   rsp_chan
);
   import i2ew_pkg::*;

   logic       push_valid;
   logic       push_ready;
   digits_type push_data;
   logic       pop_valid;
   logic       pop_ready;
   digits_type pop_data;

   i2ew_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready)
   );

   i2ew_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop_ready  (pop_ready)
   );

   i2ew_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_data  (pop_data),
      .pop_ready (pop_ready),
      .rsp       (rsp_chan)
   );

endmodule
